### sv/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg - shared types and constants of the WAV stream deframer
// Chunk tags, parser phase codes, result kinds, error codes and the result
// record that travels from the parser to the output stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Chunk tags as they appear after four little-endian bytes are gathered
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952; // "RIFF"
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157; // "WAVE"
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66; // "fmt "
	localparam logic [31:0] TAG_DATA = 32'h6174_6164; // "data"

	// Smallest fmt body that carries every field we need
	localparam logic [31:0] FMT_MIN = 32'd16;

	// Format codes accepted in the fmt body
	localparam logic [15:0] WAVE_FMT_PCM   = 16'd1;
	localparam logic [15:0] WAVE_FMT_FLOAT = 16'd3;

	// Unsigned 8-bit PCM is offset by 128; flipping the top bit removes it
	localparam logic [31:0] PCM8_FLIP = 32'd128 << 24;

	// Parser phases
	localparam logic [3:0] PH_RIFF_TAG   = 4'd0;
	localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
	localparam logic [3:0] PH_WAVE_TAG   = 4'd2;
	localparam logic [3:0] PH_FMT_TAG    = 4'd3;
	localparam logic [3:0] PH_FMT_SIZE   = 4'd4;
	localparam logic [3:0] PH_FMT_BODY   = 4'd5;
	localparam logic [3:0] PH_DATA_TAG   = 4'd6;
	localparam logic [3:0] PH_DATA_SIZE  = 4'd7;
	localparam logic [3:0] PH_SAMPLES    = 4'd8;
	localparam logic [3:0] PH_RIFF_JSIZE = 4'd9;
	localparam logic [3:0] PH_RIFF_JBODY = 4'd10;
	localparam logic [3:0] PH_FMT_JSIZE  = 4'd11;
	localparam logic [3:0] PH_FMT_JBODY  = 4'd12;
	localparam logic [3:0] PH_DATA_JSIZE = 4'd13;
	localparam logic [3:0] PH_DATA_JBODY = 4'd14;
	localparam logic [3:0] PH_HALT       = 4'd15;

	// Result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
	localparam logic [2:0] ERR_SHORT_FMT = 3'd2;
	localparam logic [2:0] ERR_BAD_FMT   = 3'd3;
	localparam logic [2:0] ERR_BAD_DEPTH = 3'd4;
	localparam logic [2:0] ERR_PCM32     = 3'd5;
	localparam logic [2:0] ERR_TRUNC     = 3'd6;

	// One result beat
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] sample_value;
		logic [15:0]        channel_count;
		logic [31:0]        sample_rate;
		logic [5:0]         bit_depth;
		logic               is_float;
		logic [31:0]        data_size;
		logic [2:0]         error_code;
	} result_t;

endpackage

### sv/wsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_if - stream channels of the WAV stream deframer
// Byte channel into the block and result channel out of it, both with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface wsd_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] sample_value;
	logic [15:0]        channel_count;
	logic [31:0]        sample_rate;
	logic [5:0]         bit_depth;
	logic               is_float;
	logic [31:0]        data_size;
	logic [2:0]         error_code;

	modport source (output valid, output kind, output sample_value, output channel_count,
		output sample_rate, output bit_depth, output is_float, output data_size,
		output error_code, input ready);
	modport sink   (input valid, input kind, input sample_value, input channel_count,
		input sample_rate, input bit_depth, input is_float, input data_size,
		input error_code, output ready);
endinterface

### sv/wsd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser - RIFF/WAVE chunk walker and sample assembler
// Holds the parse state and, for each accepted byte, works out the next
// state and at most one result in combinational logic.
// ----------------------------------------------------------------------------
module wsd_parser
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	output logic       res_valid,
	output result_t    res
);

	// Byte offsets inside the fmt body at which a field completes
	localparam logic [4:0] OFF_FORMAT   = 5'd1;
	localparam logic [4:0] OFF_CHANNELS = 5'd3;
	localparam logic [4:0] OFF_RATE     = 5'd7;
	localparam logic [4:0] OFF_DEPTH    = 5'd15;
	localparam logic [4:0] OFF_SAT      = 5'd16;

	logic [3:0]  phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] skip_q, skip_d;
	logic [4:0]  off_q, off_d;
	logic        float_q, float_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [5:0]  depth_q, depth_d;
	logic [31:0] dlen_q, dlen_d;
	logic [31:0] dcnt_q, dcnt_d;

	logic        hit;
	result_t     res_c;
	logic [31:0] sh_in;
	logic [31:0] smp;
	logic [31:0] skip_dec;
	logic [2:0]  idx_inc;
	logic        gdone;
	logic [15:0] field;

	// Tag phase to return to after a skipped chunk
	function automatic logic [3:0] tag_phase(input logic [3:0] ph);
		logic [3:0] r;
		case (ph)
			PH_RIFF_JSIZE, PH_RIFF_JBODY: r = PH_RIFF_TAG;
			PH_FMT_JSIZE, PH_FMT_JBODY:   r = PH_FMT_TAG;
			default:                      r = PH_DATA_TAG;
		endcase
		return r;
	endfunction

	assign sh_in    = {data_byte, shift_q[31:8]};
	assign idx_inc  = idx_q + 3'd1;
	assign gdone    = idx_inc[2];
	assign field    = sh_in[31:16];
	assign skip_dec = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
	assign smp      = (idx_q == 3'd0) ? {data_byte, 24'd0} : sh_in;

	// Work out the next state and the result of one byte
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		shift_d = shift_q;
		skip_d  = skip_q;
		off_d   = off_q;
		float_d = float_q;
		chan_d  = chan_q;
		rate_d  = rate_q;
		depth_d = depth_q;
		dlen_d  = dlen_q;
		dcnt_d  = dcnt_q;
		hit     = 1'b0;
		res_c   = '0;

		case (phase_q)
			PH_RIFF_TAG, PH_FMT_TAG, PH_DATA_TAG: begin
				shift_d = sh_in;
				idx_d   = gdone ? 3'd0 : idx_inc;
				if (gdone) begin
					case (phase_q)
						PH_RIFF_TAG: phase_d = (sh_in == TAG_RIFF) ? PH_RIFF_SIZE : PH_RIFF_JSIZE;
						PH_FMT_TAG:  phase_d = (sh_in == TAG_FMT) ? PH_FMT_SIZE : PH_FMT_JSIZE;
						default:     phase_d = (sh_in == TAG_DATA) ? PH_DATA_SIZE : PH_DATA_JSIZE;
					endcase
				end
			end
			PH_RIFF_SIZE: begin
				shift_d = sh_in;
				idx_d   = gdone ? 3'd0 : idx_inc;
				if (gdone) begin
					phase_d = PH_WAVE_TAG;
				end
			end
			PH_WAVE_TAG: begin
				shift_d = sh_in;
				idx_d   = gdone ? 3'd0 : idx_inc;
				if (gdone) begin
					if (sh_in != TAG_WAVE) begin
						phase_d          = PH_HALT;
						hit              = 1'b1;
						res_c.kind       = KIND_ERROR;
						res_c.error_code = ERR_NOT_WAVE;
					end else begin
						phase_d = PH_FMT_TAG;
					end
				end
			end
			PH_FMT_SIZE: begin
				shift_d = sh_in;
				idx_d   = gdone ? 3'd0 : idx_inc;
				if (gdone) begin
					if (sh_in < FMT_MIN) begin
						phase_d          = PH_HALT;
						hit              = 1'b1;
						res_c.kind       = KIND_ERROR;
						res_c.error_code = ERR_SHORT_FMT;
					end else begin
						skip_d  = sh_in;
						off_d   = 5'd0;
						phase_d = PH_FMT_BODY;
					end
				end
			end
			PH_FMT_BODY: begin
				shift_d = sh_in;
				skip_d  = skip_q - 32'd1;
				off_d   = (off_q == OFF_SAT) ? OFF_SAT : off_q + 5'd1;
				if (skip_d == 32'd0) begin
					phase_d = PH_DATA_TAG;
				end
				// Pick up each field as its last byte arrives; a check overrides the phase
				if (off_q == OFF_FORMAT) begin
					if (field != WAVE_FMT_PCM && field != WAVE_FMT_FLOAT) begin
						phase_d          = PH_HALT;
						hit              = 1'b1;
						res_c.kind       = KIND_ERROR;
						res_c.error_code = ERR_BAD_FMT;
					end else begin
						float_d = (field == WAVE_FMT_FLOAT);
					end
				end else if (off_q == OFF_CHANNELS) begin
					chan_d = field;
				end else if (off_q == OFF_RATE) begin
					rate_d = sh_in;
				end else if (off_q == OFF_DEPTH) begin
					if (!(field inside {16'd8, 16'd16, 16'd24, 16'd32})) begin
						phase_d          = PH_HALT;
						hit              = 1'b1;
						res_c.kind       = KIND_ERROR;
						res_c.error_code = ERR_BAD_DEPTH;
					end else if (field == 16'd32 && !float_q) begin
						phase_d          = PH_HALT;
						hit              = 1'b1;
						res_c.kind       = KIND_ERROR;
						res_c.error_code = ERR_PCM32;
					end else begin
						depth_d = field[5:0];
					end
				end
			end
			PH_DATA_SIZE: begin
				shift_d = sh_in;
				idx_d   = gdone ? 3'd0 : idx_inc;
				if (gdone) begin
					dlen_d              = sh_in;
					dcnt_d              = 32'd0;
					phase_d             = (chan_q != 16'd0) ? PH_SAMPLES : PH_HALT;
					hit                 = 1'b1;
					res_c.kind          = KIND_HEADER;
					res_c.channel_count = chan_q;
					res_c.sample_rate   = rate_q;
					res_c.bit_depth     = depth_q;
					res_c.is_float      = float_q;
					res_c.data_size     = sh_in;
				end
			end
			PH_SAMPLES: begin
				// Stop at the stated data length before starting a new sample
				if (idx_q == 3'd0 && dlen_q != 32'd0 && dcnt_q >= dlen_q) begin
					phase_d = PH_HALT;
				end else begin
					shift_d = smp;
					if (dcnt_q != '1) begin
						dcnt_d = dcnt_q + 32'd1;
					end
					if (idx_inc >= depth_q[5:3]) begin
						idx_d              = 3'd0;
						hit                = 1'b1;
						res_c.kind         = KIND_SAMPLE;
						res_c.sample_value = (depth_q == 6'd8) ? smp ^ PCM8_FLIP : smp;
					end else begin
						idx_d = idx_inc;
					end
				end
			end
			PH_RIFF_JSIZE, PH_FMT_JSIZE, PH_DATA_JSIZE: begin
				shift_d = sh_in;
				idx_d   = gdone ? 3'd0 : idx_inc;
				if (gdone) begin
					skip_d  = sh_in;
					phase_d = (sh_in == 32'd0) ? tag_phase(phase_q) : phase_q + 4'd1;
				end
			end
			PH_RIFF_JBODY, PH_FMT_JBODY, PH_DATA_JBODY: begin
				skip_d = skip_dec;
				if (skip_dec == 32'd0) begin
					phase_d = tag_phase(phase_q);
				end
			end
			default: begin
				// halted: drop bytes until the end of the stream
			end
		endcase

		// Flag a file cut short in the header, then restart
		if (stream_end) begin
			if (!hit && phase_d != PH_SAMPLES && phase_d != PH_HALT) begin
				hit              = 1'b1;
				res_c            = '0;
				res_c.kind       = KIND_ERROR;
				res_c.error_code = ERR_TRUNC;
			end
			phase_d = PH_RIFF_TAG;
			idx_d   = 3'd0;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF_TAG;
			idx_q   <= 3'd0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	// Held fields; each is written before it is read
	always_ff @(posedge clk) begin
		if (step) begin
			shift_q <= shift_d;
			skip_q  <= skip_d;
			off_q   <= off_d;
			float_q <= float_d;
			chan_q  <= chan_d;
			rate_q  <= rate_d;
			depth_q <= depth_d;
			dlen_q  <= dlen_d;
			dcnt_q  <= dcnt_d;
		end
	end

	assign res_valid = step && hit;
	assign res       = res_c;

	a_depth_in_samples: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SAMPLES |-> (depth_q == 6'd8 || depth_q == 6'd16 ||
			depth_q == 6'd24 || depth_q == 6'd32))
		else $error("sample phase entered without a valid bit depth");

	a_header_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_HEADER && !stream_end |=>
			(phase_q == PH_SAMPLES || phase_q == PH_HALT))
		else $error("header reported but parser did not leave the header");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SAMPLES |-> idx_q < depth_q[5:3])
		else $error("sample byte count ran past the sample width");

endmodule

### sv/wsd_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_skid - two-entry output stage
// Output register plus one skid entry, so a result can be taken in while
// the receiver stalls the previous one.
// ----------------------------------------------------------------------------
module wsd_skid
	import wsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  result_t push_data,
	output logic    space,
	wsd_result_if.source res
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;
	logic    load_out;

	assign pop      = out_valid_q && res.ready;
	assign load_out = !out_valid_q || pop;
	assign space    = !skid_valid_q;

	// Advance the skid entry or a new beat into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || push_valid;
			skid_valid_q <= 1'b0;
		end else if (push_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload follows the valid flags
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push_valid) begin
			skid_q <= push_data;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.kind          = out_q.kind;
	assign res.sample_value  = out_q.sample_value;
	assign res.channel_count = out_q.channel_count;
	assign res.sample_rate   = out_q.sample_rate;
	assign res.bit_depth     = out_q.bit_depth;
	assign res.is_float      = out_q.is_float;
	assign res.data_size     = out_q.data_size;
	assign res.error_code    = out_q.error_code;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !res.ready))
		else $error("skid entry filled without an output stall");

	a_out_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |=> out_valid_q && $stable(out_q))
		else $error("output beat changed while the receiver stalled");

endmodule

### sv/wav_stream_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_deframer_core - byte-serial WAV header parser and sample framer
// Feed a WAV file on 'stream', one byte per beat, with stream_end set on
// the last byte. Results leave on 'result': one header beat (kind 1) once
// the data chunk size is read, then one beat per complete sample (kind 0),
// or a single error beat (kind 2) after which bytes are dropped until
// stream_end.
// Throughput: one byte per cycle while the skid entry is free; the parse
// step for a byte is combinational logic from the parser state to the output
// stage. A result is presented the cycle after its byte unless stalled.
// Reset: the parser seeks the RIFF tag and the output stage is empty; the
// parser alone makes the same restart after every byte marked stream_end.
// Stall: the output stage holds two results. While the receiver holds off,
// bytes are still taken until the skid entry fills; stream.ready then drops
// until the receiver takes a beat.
// ----------------------------------------------------------------------------
module wav_stream_deframer_core
	import wsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	wsd_byte_if.sink     stream,
	wsd_result_if.source result
);

	logic    step;
	logic    res_valid;
	result_t res;
	logic    space;

	// Take a byte whenever the output stage has room for one more beat
	assign stream.ready = space;
	assign step         = stream.valid && space;

	wsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (stream.data_byte),
		.stream_end (stream.stream_end),
		.res_valid  (res_valid),
		.res        (res)
	);

	wsd_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_data  (res),
		.space      (space),
		.res        (result)
	);

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> space)
		else $error("result pushed into a full output stage");

	a_backpressure_has_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> result.valid)
		else $error("byte channel stalled with no result waiting");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result beat withdrawn before it was taken");

endmodule

### test/tb_wav_stream_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_stream_deframer_core - self-checking bench for the WAV deframer
// Builds WAV byte streams (well-formed files with random content, broken
// headers, truncated files, stray chunks and plain noise) and feeds them
// one beat at a time, with random gaps outside a steady run of files. A
// bit-accurate parser model in the bench predicts every header, sample and
// error beat. Each beat from the block is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_wav_stream_deframer_core
	import wsd_pkg::*;
();

	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_BYTES  = 1850;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PERCENT  = 35;

	// Byte offsets inside the fmt body at which a field is complete
	localparam logic [31:0] FMT_OFS_CODE  = 32'd1;
	localparam logic [31:0] FMT_OFS_CHANS = 32'd3;
	localparam logic [31:0] FMT_OFS_RATE  = 32'd7;
	localparam logic [31:0] FMT_OFS_DEPTH = 32'd15;

	localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;

	typedef enum int {
		FC_GOOD, FC_NOT_WAVE, FC_SHORT_FMT, FC_BAD_CODE, FC_BAD_DEPTH, FC_PCM32,
		FC_HEADER_CUT, FC_LEN_LIMIT, FC_NO_CHANS, FC_NOISE, FC_DATA_CUT, FC_COUNT
	} file_case_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       stream_end;
		bit         wait_drain;
		bit         steady;
	} file_beat_t;

	logic clk;
	logic arst_n;

	wsd_byte_if   byte_ch ();
	wsd_result_if res_ch ();

	wav_stream_deframer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.result (res_ch)
	);

	file_beat_t file_bytes[$];
	result_t    results_due[$];
	logic [7:0] wav_image[$];

	bit beat_taken;
	bit steady_mode;
	bit drain_before_next;
	bit steady_next;
	int fail_count;
	int stall_cycles;

	// Parser model state
	logic [3:0]  pr_phase;
	logic [2:0]  pr_count;
	logic [31:0] pr_shift;
	logic [31:0] pr_skip;
	logic [31:0] pr_fmt_len;
	logic        pr_float;
	logic [15:0] pr_chans;
	logic [31:0] pr_rate;
	logic [5:0]  pr_depth;
	logic [31:0] pr_dlen;
	logic [31:0] pr_dtaken;

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	function automatic void parser_restart();
		pr_phase   = PH_RIFF_TAG;
		pr_count   = '0;
		pr_shift   = '0;
		pr_skip    = '0;
		pr_fmt_len = '0;
		pr_float   = 1'b0;
		pr_chans   = '0;
		pr_rate    = '0;
		pr_depth   = '0;
		pr_dlen    = '0;
		pr_dtaken  = '0;
	endfunction

	// Shift a byte in at the top; true once four bytes are gathered
	function automatic bit take_four(input logic [7:0] b);
		pr_shift = {b, pr_shift[31:8]};
		pr_count = pr_count + 3'd1;
		if (pr_count >= 3'd4) begin
			pr_count = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit raise_error(input logic [2:0] code, output result_t r);
		pr_phase     = PH_HALT;
		r            = '0;
		r.kind       = KIND_ERROR;
		r.error_code = code;
		return 1'b1;
	endfunction

	// Tag phase to return to once a foreign chunk has been skipped
	function automatic logic [3:0] tag_after_skip(input logic [3:0] ph);
		case (ph)
			PH_RIFF_JSIZE, PH_RIFF_JBODY: return PH_RIFF_TAG;
			PH_FMT_JSIZE, PH_FMT_JBODY:   return PH_FMT_TAG;
			default:                      return PH_DATA_TAG;
		endcase
	endfunction

	function automatic bit parse_wav_byte(input logic [7:0] b, input logic fin,
			output result_t r);
		logic [31:0] v;
		logic [31:0] off;
		bit got;
		r   = '0;
		got = 1'b0;
		case (pr_phase)
			PH_RIFF_TAG: begin
				if (take_four(b))
					pr_phase = (pr_shift == TAG_RIFF) ? PH_RIFF_SIZE : PH_RIFF_JSIZE;
			end
			PH_FMT_TAG: begin
				if (take_four(b))
					pr_phase = (pr_shift == TAG_FMT) ? PH_FMT_SIZE : PH_FMT_JSIZE;
			end
			PH_DATA_TAG: begin
				if (take_four(b))
					pr_phase = (pr_shift == TAG_DATA) ? PH_DATA_SIZE : PH_DATA_JSIZE;
			end
			PH_RIFF_SIZE: begin
				if (take_four(b))
					pr_phase = PH_WAVE_TAG;
			end
			PH_WAVE_TAG: begin
				if (take_four(b)) begin
					if (pr_shift != TAG_WAVE)
						got = raise_error(ERR_NOT_WAVE, r);
					else
						pr_phase = PH_FMT_TAG;
				end
			end
			PH_FMT_SIZE: begin
				if (take_four(b)) begin
					pr_fmt_len = pr_shift;
					if (pr_fmt_len < FMT_MIN) begin
						got = raise_error(ERR_SHORT_FMT, r);
					end else begin
						pr_skip  = pr_fmt_len;
						pr_phase = PH_FMT_BODY;
					end
				end
			end
			PH_FMT_BODY: begin
				off      = pr_fmt_len - pr_skip;
				pr_shift = {b, pr_shift[31:8]};
				pr_skip  = pr_skip - 32'd1;
				if (off == FMT_OFS_CODE) begin
					v = pr_shift >> 16;
					if (v != 32'(WAVE_FMT_PCM) && v != 32'(WAVE_FMT_FLOAT))
						got = raise_error(ERR_BAD_FMT, r);
					else
						pr_float = (v == 32'(WAVE_FMT_FLOAT));
				end else if (off == FMT_OFS_CHANS) begin
					pr_chans = pr_shift[31:16];
				end else if (off == FMT_OFS_RATE) begin
					pr_rate = pr_shift;
				end else if (off == FMT_OFS_DEPTH) begin
					v = pr_shift >> 16;
					if (v != 32'd8 && v != 32'd16 && v != 32'd24 && v != 32'd32)
						got = raise_error(ERR_BAD_DEPTH, r);
					else if (v == 32'd32 && !pr_float)
						got = raise_error(ERR_PCM32, r);
					else
						pr_depth = v[5:0];
				end
				if (!got && pr_skip == 32'd0)
					pr_phase = PH_DATA_TAG;
			end
			PH_DATA_SIZE: begin
				if (take_four(b)) begin
					pr_dlen         = pr_shift;
					pr_dtaken       = '0;
					pr_phase        = (pr_chans != 16'd0) ? PH_SAMPLES : PH_HALT;
					r.kind          = KIND_HEADER;
					r.channel_count = pr_chans;
					r.sample_rate   = pr_rate;
					r.bit_depth     = pr_depth;
					r.is_float      = pr_float;
					r.data_size     = pr_dlen;
					got             = 1'b1;
				end
			end
			PH_SAMPLES: begin
				// Stop at the data length, but only between samples
				if (pr_count == 3'd0 && pr_dlen != 32'd0 && pr_dtaken >= pr_dlen) begin
					pr_phase = PH_HALT;
				end else begin
					if (pr_count == 3'd0)
						pr_shift = '0;
					pr_shift = {b, pr_shift[31:8]};
					if (pr_dtaken != 32'hFFFF_FFFF)
						pr_dtaken = pr_dtaken + 32'd1;
					pr_count = pr_count + 3'd1;
					if (32'(pr_count) >= 32'(pr_depth >> 3)) begin
						pr_count = '0;
						v = pr_shift;
						if (pr_depth == 6'd8)
							v = v ^ PCM8_FLIP;
						r.kind         = KIND_SAMPLE;
						r.sample_value = v;
						got            = 1'b1;
					end
				end
			end
			PH_RIFF_JSIZE, PH_FMT_JSIZE, PH_DATA_JSIZE: begin
				if (take_four(b)) begin
					pr_skip = pr_shift;
					if (pr_skip == 32'd0)
						pr_phase = tag_after_skip(pr_phase);
					else
						pr_phase = pr_phase + 4'd1;
				end
			end
			PH_RIFF_JBODY, PH_FMT_JBODY, PH_DATA_JBODY: begin
				if (pr_skip != 32'd0)
					pr_skip = pr_skip - 32'd1;
				if (pr_skip == 32'd0)
					pr_phase = tag_after_skip(pr_phase);
			end
			default: ;
		endcase
		// Last byte of the file: flag a cut header, then start over
		if (fin) begin
			if (!got && pr_phase != PH_SAMPLES && pr_phase != PH_HALT)
				got = raise_error(ERR_TRUNC, r);
			parser_restart();
		end
		return got;
	endfunction

	// ------------------------------------------------------------------
	// Stream building
	// ------------------------------------------------------------------
	task automatic append_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			wav_image.insert(wav_image.size(), v[8*i +: 8]);
	endtask

	task automatic append_junk_chunk();
		int len;
		len = $urandom_range(0, 7);
		append_le($urandom, 4);
		append_le(len, 4);
		repeat (len) append_le($urandom, 1);
	endtask

	// Queue the built image, cut after byte 'cut' when it is in range
	task automatic flush_image(input int cut);
		file_beat_t fb;
		if (cut >= 0 && cut < wav_image.size() - 1)
			wav_image = wav_image[0:cut];
		foreach (wav_image[i]) begin
			fb.data_byte  = wav_image[i];
			fb.stream_end = (i == wav_image.size() - 1);
			fb.wait_drain = drain_before_next && (i == 0);
			fb.steady     = steady_next;
			file_bytes.insert(file_bytes.size(), fb);
		end
		wav_image.delete();
	endtask

	task automatic build_wav(input logic [31:0] wave_tag, input logic [15:0] code,
			input logic [15:0] chans, input logic [15:0] depth, input logic [31:0] fmt_len,
			input logic [31:0] data_field, input int data_bytes, input logic [2:0] junk,
			input int cut);
		logic [31:0] rate;
		case ($urandom_range(3))
			0:       rate = 32'd0;
			1:       rate = 32'hFFFF_FFFF;
			2:       rate = 32'd48000;
			default: rate = $urandom;
		endcase
		wav_image.delete();
		if (junk[0])
			append_junk_chunk();
		append_le(TAG_RIFF, 4);
		append_le($urandom, 4);
		append_le(wave_tag, 4);
		if (junk[1])
			append_junk_chunk();
		append_le(TAG_FMT, 4);
		append_le(fmt_len, 4);
		append_le(32'(code), 2);
		append_le(32'(chans), 2);
		append_le(rate, 4);
		append_le($urandom, 4);
		append_le($urandom, 2);
		append_le(32'(depth), 2);
		for (int i = 16; i < int'(fmt_len); i++)
			append_le($urandom, 1);
		if (junk[2])
			append_junk_chunk();
		append_le(TAG_DATA, 4);
		append_le(data_field, 4);
		repeat (data_bytes) append_le($urandom, 1);
		flush_image(cut);
	endtask

	task automatic random_file(input file_case_t fc);
		logic [31:0] wave_tag;
		logic [15:0] code;
		logic [15:0] chans;
		logic [15:0] depth;
		logic [31:0] fmt_len;
		logic [31:0] data_field;
		int          data_bytes;
		logic [2:0]  junk;
		int          cut;
		// Well-formed defaults
		wave_tag = TAG_WAVE;
		code     = $urandom_range(1) ? WAVE_FMT_PCM : WAVE_FMT_FLOAT;
		depth    = 16'(($urandom_range(code == WAVE_FMT_FLOAT ? 3 : 2) + 1) * 8);
		case ($urandom_range(7))
			0:       chans = 16'hFFFF;
			1:       chans = 16'($urandom_range(3, 8));
			default: chans = 16'($urandom_range(1, 2));
		endcase
		fmt_len    = ($urandom_range(3) == 0) ? 32'd16 + $urandom_range(1, 8) : 32'd16;
		data_bytes = $urandom_range(0, 24);
		case ($urandom_range(3))
			0:       data_field = 32'd0;
			1:       data_field = data_bytes;
			2:       data_field = $urandom_range(1) ? data_bytes + $urandom_range(1, 100)
			                                        : 32'hFFFF_FFFF;
			default: data_field = $urandom_range(0, data_bytes);
		endcase
		junk = ($urandom_range(3) == 0) ? 3'($urandom) : 3'd0;
		cut  = -1;
		// Break or bend the file as the case asks
		case (fc)
			FC_NOT_WAVE:  wave_tag = TAG_WAVE ^ (32'd1 << $urandom_range(31));
			FC_SHORT_FMT: fmt_len = $urandom_range(0, 15);
			FC_BAD_CODE: begin
				do code = 16'($urandom); while (code == WAVE_FMT_PCM || code == WAVE_FMT_FLOAT);
			end
			FC_BAD_DEPTH: begin
				if ($urandom_range(3) == 0)
					depth = 16'hFFFF;
				else
					do depth = 16'($urandom_range(0, 40));
					while (depth == 16'd8 || depth == 16'd16 || depth == 16'd24 || depth == 16'd32);
			end
			FC_PCM32: begin
				code  = WAVE_FMT_PCM;
				depth = 16'd32;
			end
			FC_HEADER_CUT: begin
				junk = 3'd0;
				cut  = $urandom_range(0, 42);
			end
			FC_LEN_LIMIT: begin
				data_bytes = $urandom_range(4, 24);
				data_field = $urandom_range(1, data_bytes - 1);
			end
			FC_NO_CHANS: chans = 16'd0;
			FC_DATA_CUT: begin
				data_field = 32'd0;
				data_bytes = $urandom_range(1, 24);
			end
			default: ;
		endcase
		if (fc == FC_NOISE) begin
			wav_image.delete();
			repeat ($urandom_range(1, 12)) append_le($urandom, 1);
			flush_image(-1);
		end else begin
			build_wav(wave_tag, code, chans, depth, fmt_len, data_field, data_bytes, junk, cut);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Byte driver and result ready, changed on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		file_beat_t nb;
		if (arst_n) begin
			if (!byte_ch.valid || beat_taken) begin
				if (file_bytes.size() != 0 && file_bytes[0].wait_drain
						&& results_due.size() != 0) begin
					// hold the next file until everything owed has come out
					byte_ch.valid <= 1'b0;
				end else if (file_bytes.size() == 0
						|| (!steady_mode && $urandom_range(99) < IDLE_PERCENT)) begin
					byte_ch.valid <= 1'b0;
				end else begin
					nb = file_bytes.pop_front();
					steady_mode        <= nb.steady;
					byte_ch.valid      <= 1'b1;
					byte_ch.data_byte  <= nb.data_byte;
					byte_ch.stream_end <= nb.stream_end;
				end
			end
			res_ch.ready <= steady_mode || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// ------------------------------------------------------------------
	// Sample both channels on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		result_t got;
		bit      has;
		beat_taken <= byte_ch.valid && byte_ch.ready;
		if (arst_n) begin
			// predict from each accepted byte
			if (byte_ch.valid && byte_ch.ready) begin
				has = parse_wav_byte(byte_ch.data_byte, byte_ch.stream_end, want);
				if (has)
					results_due.insert(results_due.size(), want);
			end
			// compare each result beat with the oldest prediction
			if (res_ch.valid && res_ch.ready) begin
				got.kind          = res_ch.kind;
				got.sample_value  = res_ch.sample_value;
				got.channel_count = res_ch.channel_count;
				got.sample_rate   = res_ch.sample_rate;
				got.bit_depth     = res_ch.bit_depth;
				got.is_float      = res_ch.is_float;
				got.data_size     = res_ch.data_size;
				got.error_code    = res_ch.error_code;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, got);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", 32'(want.kind), 32'(got.kind));
					check_field("sample_value", want.sample_value, got.sample_value);
					check_field("channel_count", 32'(want.channel_count),
						32'(got.channel_count));
					check_field("sample_rate", want.sample_rate, got.sample_rate);
					check_field("bit_depth", 32'(want.bit_depth), 32'(got.bit_depth));
					check_field("is_float", 32'(want.is_float), 32'(got.is_float));
					check_field("data_size", want.data_size, got.data_size);
					check_field("error_code", 32'(want.error_code), 32'(got.error_code));
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int base;
		int file_no;
		int pick;
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.stream_end = 1'b0;
		res_ch.ready       = 1'b0;
		beat_taken         = 1'b0;
		steady_mode        = 1'b0;
		drain_before_next  = 1'b0;
		steady_next        = 1'b0;
		fail_count         = 0;
		stall_cycles       = 0;
		parser_restart();

		// Short directed streams: lone bytes, a bare tag, an odd stray chunk
		append_le(32'h00, 1);
		flush_image(-1);
		append_le(32'hFF, 1);
		flush_image(-1);
		append_le(TAG_RIFF, 4);
		flush_image(-1);
		append_le(TAG_JUNK, 4);
		append_le(32'd1, 4);
		append_le(32'hA5, 1);
		flush_image(-1);

		// Random files: each case once, then mostly well-formed
		base    = file_bytes.size();
		file_no = 0;
		while (file_bytes.size() - base < RANDOM_BYTES) begin
			drain_before_next = (file_no % 9 == 0);
			steady_next       = (file_no >= 12 && file_no < 22);
			if (file_no < int'(FC_COUNT)) begin
				random_file(file_case_t'(file_no));
			end else begin
				pick = $urandom_range(99);
				if (pick < 60)
					random_file(FC_GOOD);
				else if (pick < 70)
					random_file(FC_DATA_CUT);
				else if (pick < 76)
					random_file(FC_LEN_LIMIT);
				else
					random_file(file_case_t'($urandom_range(1, 9)));
			end
			file_no++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain, then give the output stage time to show any stray beat
		while (file_bytes.size() != 0 || byte_ch.valid || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
sv/wsd_pkg.sv
sv/wsd_if.sv
sv/wsd_parser.sv
sv/wsd_skid.sv
sv/wav_stream_deframer_core.sv
test/tb_wav_stream_deframer_core.sv
